/* design/dsc_pkg.sv */
// Shared types and constants for the nucleotide symbol counter.
`timescale 1ns / 1ps

package dsc_pkg;

    // Fixed field widths
    localparam int SYMBOL_W     = 8;
    localparam int MODE_W       = 2;
    localparam int OUT_COUNT_W  = 48;
    localparam int COUNT_W_DEF  = 48;

    // Format mode codes
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FASTA = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FASTQ = 2'd2;

    // Byte codes the parser reacts to
    localparam logic [SYMBOL_W-1:0] CHAR_GT = 8'h3E;  // '>'
    localparam logic [SYMBOL_W-1:0] CHAR_NL = 8'h0A;  // newline
    localparam logic [SYMBOL_W-1:0] CHAR_A  = 8'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_C  = 8'h43;
    localparam logic [SYMBOL_W-1:0] CHAR_G  = 8'h47;
    localparam logic [SYMBOL_W-1:0] CHAR_T  = 8'h54;

    // One input item as held in the input register
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                end_of_file;
    } item_t;

    // True for the upper-case nucleotide letters
    function automatic logic is_base(input logic [SYMBOL_W-1:0] sym);
        is_base = (sym == CHAR_A) || (sym == CHAR_C) || (sym == CHAR_G) || (sym == CHAR_T);
    endfunction

endpackage

/* design/dsc_input_reg.sv */
// Input register stage: captures one byte item per cycle from the slave side while it is empty or being drained.
`timescale 1ns / 1ps

module dsc_input_reg
    import dsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    output logic                item_valid,
    input  logic                item_take,
    output item_t               item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Accept whenever the register is empty or drains this cycle
    assign in_ready = !valid_reg || item_take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/dsc_count_core.sv */
// Parser trackers, saturating counter and result register.
`timescale 1ns / 1ps

module dsc_count_core
    import dsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [MODE_W-1:0]      cfg_wdata,
    input  logic                   item_valid,
    output logic                   item_take,
    input  item_t                  item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_counted,
    output logic [OUT_COUNT_W-1:0] out_count,
    output logic                   out_done
);

    logic [MODE_W-1:0]      mode_reg;
    logic                   header_reg;
    logic                   header_next;
    logic [1:0]             line_reg;
    logic [1:0]             line_next;
    logic                   seq_reg;
    logic                   seq_next;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   counted_reg;
    logic                   done_reg;
    logic [OUT_COUNT_W-1:0] count_reg;
    logic [OUT_COUNT_W-1:0] count_view;
    logic                   is_nl;
    logic                   allow;
    logic                   counted;
    logic                   saturated;

    // Take the next item when the result register is free or drains now
    assign item_take = item_valid && (!valid_reg || out_ready);

    // Advance the trackers on this byte
    always_comb
    begin
        is_nl       = (item.symbol == CHAR_NL);
        header_next = header_reg;
        line_next   = line_reg;
        seq_next    = seq_reg;
        if (item.symbol == CHAR_GT)
        begin
            header_next = 1'b1;
        end
        else if (is_nl)
        begin
            header_next = 1'b0;
        end
        if (is_nl)
        begin
            seq_next  = (line_reg == 2'd0);
            line_next = line_reg + 2'd1;
        end
    end

    // Decide whether the byte counts in the current mode
    always_comb
    begin
        case (mode_reg)
            MODE_FASTA: allow = !header_next;
            MODE_FASTQ: allow = seq_next;
            default:    allow = 1'b1;
        endcase
        counted    = is_base(item.symbol) && allow;
        saturated  = (total_reg == {COUNT_WIDTH{1'b1}});
        total_next = total_reg;
        if (counted && !saturated)
        begin
            total_next = total_reg + COUNT_WIDTH'(1);
        end
    end

    // Show the low bits of the count on the result, zero-extended when the counter is narrower
    generate
        if (COUNT_WIDTH >= OUT_COUNT_W)
        begin : g_count_trunc
            assign count_view = total_next[OUT_COUNT_W-1:0];
        end
        else
        begin : g_count_ext
            assign count_view = {{(OUT_COUNT_W-COUNT_WIDTH){1'b0}}, total_next};
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        if (item_take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold mode, parser state, count and result valid; clear parser and count at end of file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FASTA;
            header_reg <= 1'b1;
            line_reg   <= 2'd0;
            seq_reg    <= 1'b0;
            total_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (item_take)
            begin
                if (item.end_of_file)
                begin
                    header_reg <= 1'b1;
                    line_reg   <= 2'd0;
                    seq_reg    <= 1'b0;
                    total_reg  <= '0;
                end
                else
                begin
                    header_reg <= header_next;
                    line_reg   <= line_next;
                    seq_reg    <= seq_next;
                    total_reg  <= total_next;
                end
            end
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            counted_reg <= counted;
            count_reg   <= count_view;
            done_reg    <= item.end_of_file;
        end
    end

    assign out_valid   = valid_reg;
    assign out_counted = counted_reg;
    assign out_count   = count_reg;
    assign out_done    = done_reg;

endmodule

/* design/dna_sequence_symbol_counter_top.sv */
// Top level of the nucleotide symbol counter for raw, FASTA and FASTQ bytes.
//
//  channel   direction  tdata               tuser     tlast
//  s_axis    in         symbol[7:0]         -         end_of_file
//  m_axis    out        running_count[47:0] counted   file_done
//  cfg       in         format_mode[1:0] on cfg_wdata, written when cfg_we is high
//
// One item per cycle sustained while m_axis_tready stays high; an accepted input passes
// the input register, then the result register behind the tracker logic, before its
// result shows.
// The input register keeps accepting while a result waits, so one stalled result
// plus one held item fill the block before s_axis_tready drops.
// Reset clears the trackers, the count and both valid flags; format_mode resets
// to FASTA. A result with tlast set returns trackers and count to reset.
`timescale 1ns / 1ps

module dna_sequence_symbol_counter_top
    import dsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [MODE_W-1:0]      cfg_wdata,      // format_mode
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SYMBOL_W-1:0]    s_axis_tdata,   // symbol[7:0]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_COUNT_W-1:0] m_axis_tdata,   // running_count[47:0]
    output logic                   m_axis_tuser,   // counted
    output logic                   m_axis_tlast
);

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  item_take;

    assign in_item.symbol      = s_axis_tdata;
    assign in_item.end_of_file = s_axis_tlast;

    // Register the incoming byte
    dsc_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    // Track format state and count
    dsc_count_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item        (item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_counted (m_axis_tuser),
        .out_count   (m_axis_tdata),
        .out_done    (m_axis_tlast)
    );

endmodule

/* design/dsc_checker.sv */
// Port-level checks for the nucleotide symbol counter, bound to the top level.
`timescale 1ns / 1ps

module dsc_checker
    import dsc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_COUNT_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    // No result shows while reset is held
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // Input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // A stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // An item taken by an idle block shows via input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
        else $error("result missing after accepted item");

endmodule

bind dna_sequence_symbol_counter_top dsc_checker u_dsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* verif/tb.sv */
// Self-checking testbench for the nucleotide symbol counter across all format modes.
`timescale 1ns / 1ps

module tb;
    import dsc_pkg::*;

    // Counter narrower than the result field, so the zero-extended count view is exercised
    localparam int CNT_W        = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 700;
    localparam int RUN_BASES    = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    // Mode code and byte codes that the package does not name
    localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;
    localparam logic [SYMBOL_W-1:0] CHAR_N     = 8'h4E;
    localparam logic [SYMBOL_W-1:0] CHAR_AT    = 8'h40;
    localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [SYMBOL_W-1:0] CHAR_LOW_T = 8'h74;
    localparam logic [CNT_W-1:0]    TOTAL_MAX  = '1;

    typedef enum int { TXT_RAW, TXT_FASTA, TXT_FASTQ, TXT_NOISE } text_kind_e;

    // One expected result item
    typedef struct packed {
        logic                   counted;
        logic [OUT_COUNT_W-1:0] count;
        logic                   done;
    } tally_t;

    logic                   clk           = 1'b0;
    logic                   rst_n;
    logic                   cfg_we        = 1'b0;
    logic [MODE_W-1:0]      cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SYMBOL_W-1:0]    s_axis_tdata  = '0;    // symbol[7:0]
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_COUNT_W-1:0] m_axis_tdata;          // running_count[47:0]
    logic                   m_axis_tuser;          // counted
    logic                   m_axis_tlast;

    // Mirror of the block's format register and parser state
    logic [MODE_W-1:0] fmt_mode    = MODE_FASTA;
    logic              in_header   = 1'b1;
    logic [1:0]        rec_line    = 2'd0;
    logic              on_seq_line = 1'b0;
    logic [CNT_W-1:0]  nt_total    = '0;

    tally_t              pending_tallies[$];
    logic [SYMBOL_W-1:0] file_text[$];

    // Idling controls shared by the sender and the receiver
    logic tx_gaps_on  = 1'b0;
    logic rx_stall_on = 1'b0;
    int   burst_left  = 0;
    int   hold_req    = 0;
    int   hold_ack    = 0;

    int cycle_count    = 0;
    int items_sent     = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int counted_seen   = 0;
    int files_closed   = 0;
    int cfg_writes     = 0;
    int sat_hits       = 0;
    int in_stalls      = 0;

    dna_sequence_symbol_counter_top #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Advance the parsers by one byte and queue the result it should give
    function automatic void tally_symbol(input logic [SYMBOL_W-1:0] sym, input logic eof);
        logic   nl;
        logic   nucleotide;
        logic   allow;
        tally_t t;
        nl         = (sym == CHAR_NL);
        nucleotide = (sym == CHAR_A) || (sym == CHAR_C) || (sym == CHAR_G) || (sym == CHAR_T);
        // FASTA header flag: set at '>', cleared at newline
        if (sym == CHAR_GT)
            in_header = 1'b1;
        else if (nl)
            in_header = 1'b0;
        // FASTQ line within the four-line record
        if (nl)
        begin
            on_seq_line = (rec_line == 2'd0);
            rec_line    = rec_line + 2'd1;
        end
        case (fmt_mode)
            MODE_FASTA: allow = !in_header;
            MODE_FASTQ: allow = on_seq_line;
            default:    allow = 1'b1;
        endcase
        t.counted = nucleotide && allow;
        // Hold the total at its maximum
        if (t.counted && nt_total == TOTAL_MAX)
            sat_hits++;
        else if (t.counted)
            nt_total = nt_total + 1'b1;
        t.count = OUT_COUNT_W'(nt_total);
        t.done  = eof;
        pending_tallies.push_back(t);
        // Return to the reset state after the last byte of a file
        if (eof)
        begin
            in_header   = 1'b1;
            rec_line    = 2'd0;
            on_seq_line = 1'b0;
            nt_total    = '0;
        end
    endfunction

    // Offer one byte in bursts with random gaps when tx_gaps_on is set; return once it is accepted
    task automatic send_byte(input logic [SYMBOL_W-1:0] sym, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            gap        = tx_gaps_on ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= SYMBOL_W'($urandom);
                s_axis_tlast  <= 1'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= eof;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        tally_symbol(sym, eof);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_file(input logic close);
        foreach (file_text[i])
            send_byte(file_text[i], close && (i == file_text.size() - 1));
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input logic [MODE_W-1:0] mode);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= MODE_W'($urandom);
        fmt_mode = mode;
        cfg_writes++;
    endtask

    // Sequence text: mostly bases, with N, lower case and stray bytes
    function automatic logic [SYMBOL_W-1:0] seq_char();
        case ($urandom_range(0, 15))
            0, 1, 2:   seq_char = CHAR_A;
            3, 4, 5:   seq_char = CHAR_C;
            6, 7, 8:   seq_char = CHAR_G;
            9, 10, 11: seq_char = CHAR_T;
            12:        seq_char = CHAR_N;
            13, 14:    seq_char = CHAR_LOW_A + SYMBOL_W'($urandom_range(0, 25));
            default:   seq_char = SYMBOL_W'($urandom);
        endcase
    endfunction

    // Append one line of sequence or printable text and its newline
    function automatic void add_line(input int len, input logic seq_text);
        repeat (len)
            file_text.push_back(seq_text ? seq_char() : SYMBOL_W'($urandom_range(33, 126)));
        file_text.push_back(CHAR_NL);
    endfunction

    task automatic build_file(input text_kind_e kind);
        int seq_len;
        file_text.delete();
        repeat ($urandom_range(1, 3))
        begin
            case (kind)
                TXT_FASTA:
                begin
                    file_text.push_back(CHAR_GT);
                    add_line($urandom_range(0, 8), 1'b0);
                    repeat ($urandom_range(1, 3)) add_line($urandom_range(1, 16), 1'b1);
                end
                TXT_FASTQ:
                begin
                    seq_len = $urandom_range(1, 16);
                    file_text.push_back(CHAR_AT);
                    add_line($urandom_range(0, 8), 1'b0);
                    add_line(seq_len, 1'b1);
                    file_text.push_back(CHAR_PLUS);
                    add_line(0, 1'b0);
                    add_line(seq_len, 1'b0);
                end
                TXT_RAW:
                    add_line($urandom_range(0, 24), 1'b1);
                default:
                    repeat ($urandom_range(4, 24)) file_text.push_back(SYMBOL_W'($urandom));
            endcase
        end
        // Break some files: damage one byte, or cut off the tail
        if ($urandom_range(0, 5) == 0)
            file_text[$urandom_range(0, file_text.size() - 1)] = SYMBOL_W'($urandom);
        if ($urandom_range(0, 5) == 0)
        begin
            while (file_text.size() > 1 && $urandom_range(0, 3) != 0)
                void'(file_text.pop_back());
        end
    endtask

    // Raw mode counts every upper-case base, even inside the reset header state
    task automatic test_raw_bytes();
        write_format(MODE_RAW);
        file_text = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_LOW_T, CHAR_N, 8'h00, 8'hFF};
        send_file(1'b1);
    endtask

    // FASTA skips the opening header and every '>' line
    task automatic test_fasta_headers();
        write_format(MODE_FASTA);
        file_text = '{CHAR_A, CHAR_NL, CHAR_GT, CHAR_T, CHAR_NL, CHAR_G};
        send_file(1'b1);
    endtask

    // FASTQ counts only the line after the record header
    task automatic test_fastq_records();
        write_format(MODE_FASTQ);
        file_text = '{CHAR_AT, CHAR_NL, CHAR_A, CHAR_NL, CHAR_PLUS, CHAR_NL,
                      CHAR_C, CHAR_NL, CHAR_G};
        send_file(1'b1);
    endtask

    // Switch modes in the middle of a file; the unused code counts like raw
    task automatic test_mode_switch();
        write_format(MODE_FASTQ);
        file_text = '{CHAR_AT, CHAR_NL};
        send_file(1'b0);
        write_format(MODE_FASTA);
        send_byte(CHAR_A, 1'b0);
        write_format(MODE_SPARE);
        send_byte(CHAR_T, 1'b1);
    endtask

    // Count a long run of bases back to back, then check that end of file clears it
    task automatic test_count_clear();
        int                  i;
        logic [SYMBOL_W-1:0] sym;
        write_format(MODE_RAW);
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        for (i = 0; i < RUN_BASES; i++)
        begin
            case (i % 4)
                0:       sym = CHAR_A;
                1:       sym = CHAR_C;
                2:       sym = CHAR_G;
                default: sym = CHAR_T;
            endcase
            send_byte(sym, 1'b0);
        end
        file_text = '{CHAR_NL, CHAR_N, CHAR_T};
        send_file(1'b1);
        send_byte(CHAR_G, 1'b1);
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_output_backpressure();
        int i;
        write_format(MODE_FASTA);
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        hold_req++;
        for (i = 0; i < 48; i++)
            send_byte((i % 12 == 11) ? CHAR_NL : seq_char(), i == 47);
    endtask

    // Random phases of well-formed files with some noise and broken files
    task automatic test_random_files();
        int                stop_at;
        logic [MODE_W-1:0] mode;
        text_kind_e        kind;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 7))
                0:       mode = MODE_RAW;
                1, 2, 3: mode = MODE_FASTA;
                4, 5, 6: mode = MODE_FASTQ;
                default: mode = MODE_SPARE;
            endcase
            write_format(mode);
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 6) == 0)
                    kind = TXT_NOISE;
                else if (mode == MODE_FASTA)
                    kind = TXT_FASTA;
                else if (mode == MODE_FASTQ)
                    kind = TXT_FASTQ;
                else
                    kind = TXT_RAW;
                build_file(kind);
                // Leave some files open so that the next phase continues them
                send_file($urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Drive output ready: long hold-offs on request, else always ready or a rotating stall pattern
    initial
    begin : sink_side
        int          hold_left;
        int          pat_left;
        logic [31:0] rx_pattern;
        hold_left  = 0;
        pat_left   = 0;
        rx_pattern = '1;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_stall_on)
                m_axis_tready <= 1'b1;
            else
            begin
                // Refresh the pattern, leaning toward ready or toward stall
                if (pat_left == 0)
                begin
                    rx_pattern = $urandom_range(0, 1) ? ($urandom | $urandom)
                                                      : ($urandom & $urandom);
                    pat_left   = 32;
                end
                m_axis_tready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
                pat_left--;
            end
        end
    end

    // Compare each accepted result item with the oldest expectation
    always @(posedge clk)
    begin : result_check
        tally_t want;
        if (rst_n && s_axis_tvalid && !s_axis_tready)
            in_stalls++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            counted_seen += m_axis_tuser;
            files_closed += m_axis_tlast;
            if (pending_tallies.size() == 0)
            begin
                $error("result with no item pending: running_count %0d", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                if (m_axis_tuser !== want.counted)
                begin
                    $error("counted: expected %0b, actual %0b", want.counted, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata !== want.count)
                begin
                    $error("running_count: expected %0d, actual %0d", want.count, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.done)
                begin
                    $error("file_done: expected %0b, actual %0b", want.done, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if it hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : test_flow
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        test_raw_bytes();
        test_fasta_headers();
        test_fastq_records();
        test_mode_switch();
        test_count_clear();
        test_output_backpressure();
        test_random_files();
        drain();
        $display("Checked %0d results from %0d items after %0d mode writes:",
                 results_seen, items_sent, cfg_writes);
        $display("%0d counted, %0d files, %0d bytes at maximum, input stalled %0d cycles.",
                 counted_seen, files_closed, sat_hits, in_stalls);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
